// File: src/ltmd_pkg.sv
// shared types and constants for the light tracker motor drive
`timescale 1ns / 1ps

package ltmd_pkg;

  localparam int unsigned FRACTION_BITS_DEF = 8;

  localparam int unsigned SMP_W  = 16;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned PER_W  = 20;
  localparam int unsigned CFG_W  = 20;
  localparam int unsigned CIDX_W = 3;
  localparam int unsigned IND_W  = 2;

  // shared multiplier: 20 x 7 bits, divider dividend padded to an even width
  localparam int unsigned MUL_W = PER_W + PCT_W;
  localparam int unsigned DIV_W = MUL_W + 1;
  localparam int unsigned DVS_W = 16;

  localparam logic [SMP_W-1:0] DEADZONE_RST   = 16'd1800;
  localparam logic [PCT_W-1:0] MIN_SPEED_RST  = 7'd35;
  localparam logic [PCT_W-1:0] TOP_SPEED_RST  = 7'd75;
  localparam logic [PER_W-1:0] PERIOD_RST     = 20'd50000;
  localparam logic [SMP_W-1:0] FULL_SCALE_RST = 16'd30000;
  localparam logic [PCT_W-1:0] GAIN_RST       = 7'd35;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] PCT_MID  = 7'd50;

  typedef enum logic [CIDX_W-1:0] {
    CFG_DEADZONE   = 3'd0,
    CFG_MIN_SPEED  = 3'd1,
    CFG_TOP_SPEED  = 3'd2,
    CFG_PWM_PERIOD = 3'd3,
    CFG_FULL_SCALE = 3'd4,
    CFG_ROT_GAIN   = 3'd5
  } cfg_idx_t;

  localparam logic [IND_W-1:0] IND_IDLE = 2'd0;
  localparam logic [IND_W-1:0] IND_POS  = 2'd1;
  localparam logic [IND_W-1:0] IND_NEG  = 2'd2;

  typedef struct packed {
    logic [SMP_W-1:0] sample_up;
    logic [SMP_W-1:0] sample_down;
    logic [SMP_W-1:0] sample_right;
    logic [SMP_W-1:0] sample_left;
  } in_item_t;

  typedef struct packed {
    logic             tilt_up;
    logic             tilt_down;
    logic             tilt_enable;
    logic [PER_W-1:0] tilt_compare;
    logic [PER_W-1:0] rotation_compare;
    logic [IND_W-1:0] tilt_indicator;
    logic [IND_W-1:0] rotation_indicator;
    logic [SMP_W-1:0] smooth_up;
    logic [SMP_W-1:0] smooth_down;
    logic [SMP_W-1:0] smooth_right;
    logic [SMP_W-1:0] smooth_left;
  } out_item_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_stat_t;

endpackage

// File: src/ltmd_div.sv
// iterative unsigned divider, two quotient bits per cycle
`timescale 1ns / 1ps

module ltmd_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ltmd_pkg::DIV_W-1:0] dividend,
  input  logic [ltmd_pkg::DVS_W-1:0] divisor,
  output ltmd_pkg::div_stat_t        stat
);
  import ltmd_pkg::*;

  localparam int unsigned STEPS = DIV_W / 2;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic [DIV_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0]   t1, t2;
  logic [DVS_W-1:0] r1, r2;
  logic             q1, q2;

  // two chained restoring steps
  always_comb begin
    t1 = {rem_r, quo_r[DIV_W-1]};
    q1 = (t1 >= {1'b0, dvs_r});
    r1 = q1 ? DVS_W'(t1 - {1'b0, dvs_r}) : t1[DVS_W-1:0];
    t2 = {r1, quo_r[DIV_W-2]};
    q2 = (t2 >= {1'b0, dvs_r});
    r2 = q2 ? DVS_W'(t2 - {1'b0, dvs_r}) : t2[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= r2;
        quo_r <= {quo_r[DIV_W-3:0], q1, q2};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.done     = done_r;
  assign stat.quotient = quo_r;

endmodule

// File: src/light_tracker_motor_drive.sv
// light tracker motor drive: sensor smoothing, tilt and rotation pwm compare values
// steps from input accept to out_valid: smoothing of each channel in turn, a difference
//   step, four multiply/divide passes through the shared 2-bit-per-cycle divider, a result load
// a new item is accepted only once the previous result has gone to the output register
// rst_n (synchronous) clears the averages, loads register defaults, empties output
`timescale 1ns / 1ps

module light_tracker_motor_drive #(
  parameter int unsigned FRACTION_BITS = ltmd_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ltmd_pkg::in_item_t          in_data,
  // result items
  output logic                        out_valid,
  input  logic                        out_stall,
  output ltmd_pkg::out_item_t         out_data,
  // register writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ltmd_pkg::CIDX_W-1:0] cfg_index,
  input  logic [ltmd_pkg::CFG_W-1:0]  cfg_data
);
  import ltmd_pkg::*;

  localparam int unsigned AW    = SMP_W + FRACTION_BITS;  // average width
  localparam int unsigned QT_W  = SMP_W + PCT_W + 1;      // tilt quotient bound
  localparam int unsigned SPD_W = QT_W + 2;               // signed speed

  typedef enum logic [2:0] {
    S_IDLE, S_SMOOTH, S_DIFF, S_MUL, S_WAIT, S_DONE
  } state_t;

  // the four passes through the multiplier and divider
  typedef enum logic [1:0] {
    PH_TILT, PH_TCMP, PH_ROT, PH_RCMP
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r;

  // configuration registers
  logic [SMP_W-1:0] deadzone_r;
  logic [PCT_W-1:0] min_speed_r;
  logic [PCT_W-1:0] top_speed_r;
  logic [PER_W-1:0] period_r;
  logic [SMP_W-1:0] full_scale_r;
  logic [PCT_W-1:0] gain_r;

  // averages and latched samples, index 0 up, 1 down, 2 right, 3 left
  logic [AW-1:0]    avg_r [4];
  logic [SMP_W-1:0] smp_r [4];
  logic [1:0]       idx_r;

  // per-item working registers
  logic [SMP_W-1:0] av_r, ah_r;
  logic             dh_neg_r;
  logic [IND_W-1:0] tilt_ind_r, rot_ind_r;
  logic             span_neg_r;
  logic [PCT_W-1:0] span_mag_r;
  logic [PCT_W-1:0] speed_r, duty_r;
  logic             en_r, up_r, down_r;
  logic [PER_W-1:0] tilt_cmp_r, rot_cmp_r;

  logic      out_valid_r;
  out_item_t out_r;

  // smoothing datapath, one channel a cycle
  logic [AW-1:0]      sm_cur, sm_tgt, sm_new;
  logic signed [AW:0] sm_diff, sm_step, sm_sum;

  // differences
  logic [SMP_W-1:0]      int_up, int_down, int_right, int_left;
  logic signed [SMP_W:0] dv, dh;
  logic signed [PCT_W:0] span;

  // shared multiplier and divider
  logic [PER_W-1:0] mul_a;
  logic [PCT_W-1:0] mul_b;
  logic [MUL_W-1:0] mul_p;
  logic [DVS_W-1:0] fs_eff, div_dvs;
  div_stat_t        div_st;

  // result shaping after each divide
  logic [QT_W-1:0]         qt;
  logic signed [SPD_W-1:0] spd_raw, spd_clip;
  logic                    spd_pos;
  logic [PCT_W-1:0]        spd_sat, duty_c;

  logic in_acc, out_acc, out_load;

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // exponential average, step is the floor of a quarter of the error
  always_comb begin
    sm_cur  = avg_r[idx_r];
    sm_tgt  = {smp_r[idx_r], {FRACTION_BITS{1'b0}}};
    sm_diff = $signed({1'b0, sm_tgt}) - $signed({1'b0, sm_cur});
    sm_step = sm_diff >>> 2;
    sm_sum  = $signed({1'b0, sm_cur}) + sm_step;
    sm_new  = sm_sum[AW-1:0];
  end

  always_comb begin
    int_up    = avg_r[0][AW-1 -: SMP_W];
    int_down  = avg_r[1][AW-1 -: SMP_W];
    int_right = avg_r[2][AW-1 -: SMP_W];
    int_left  = avg_r[3][AW-1 -: SMP_W];
    dv   = $signed({1'b0, int_up}) - $signed({1'b0, int_down});
    dh   = $signed({1'b0, int_right}) - $signed({1'b0, int_left});
    span = $signed({1'b0, top_speed_r}) - $signed({1'b0, min_speed_r});
  end

  // operand select for the shared multiplier, divisor select for the divider
  always_comb begin
    fs_eff = (full_scale_r == '0) ? DVS_W'(1) : full_scale_r;
    unique case (phase_r)
      PH_TILT: begin
        mul_a   = PER_W'(av_r);
        mul_b   = span_mag_r;
        div_dvs = fs_eff;
      end
      PH_TCMP: begin
        mul_a   = period_r;
        mul_b   = speed_r;
        div_dvs = DVS_W'(PCT_FULL);
      end
      PH_ROT: begin
        mul_a   = PER_W'(ah_r);
        mul_b   = gain_r;
        div_dvs = fs_eff;
      end
      PH_RCMP: begin
        mul_a   = period_r;
        mul_b   = duty_r;
        div_dvs = DVS_W'(PCT_FULL);
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        div_dvs = fs_eff;
      end
    endcase
    mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);
  end

  // the divider registers the product on start
  ltmd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_MUL),
    .dividend ({1'b0, mul_p}),
    .divisor  (div_dvs),
    .stat     (div_st)
  );

  // tilt speed: min plus signed quotient, inside deadzone zero, clamp to max then to 0..100
  always_comb begin
    qt       = div_st.quotient[QT_W-1:0];
    spd_raw  = span_neg_r ? $signed(SPD_W'(min_speed_r)) - $signed({2'b00, qt})
                          : $signed(SPD_W'(min_speed_r)) + $signed({2'b00, qt});
    if (av_r < deadzone_r) begin
      spd_clip = '0;
    end else if (spd_raw > $signed(SPD_W'(top_speed_r))) begin
      spd_clip = $signed(SPD_W'(top_speed_r));
    end else begin
      spd_clip = spd_raw;
    end
    spd_pos = (spd_clip > 0);
    if (!spd_pos) begin
      spd_sat = '0;
    end else if (spd_clip > $signed(SPD_W'(PCT_FULL))) begin
      spd_sat = PCT_FULL;
    end else begin
      spd_sat = spd_clip[PCT_W-1:0];
    end
  end

  // rotation duty: 50 plus signed quotient outside deadzone, saturated 0..100
  always_comb begin
    if (ah_r <= deadzone_r) begin
      duty_c = PCT_MID;
    end else if (div_st.quotient > DIV_W'(PCT_MID)) begin
      duty_c = dh_neg_r ? '0 : PCT_FULL;
    end else if (dh_neg_r) begin
      duty_c = PCT_MID - div_st.quotient[PCT_W-1:0];
    end else begin
      duty_c = PCT_MID + div_st.quotient[PCT_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_SMOOTH;
      S_SMOOTH: if (idx_r == 2'd3) state_nxt = S_DIFF;
      S_DIFF:   state_nxt = S_MUL;
      S_MUL:    state_nxt = S_WAIT;
      S_WAIT: begin
        if (div_st.done) state_nxt = (phase_r == PH_RCMP) ? S_DONE : S_MUL;
      end
      S_DONE:   if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_TILT;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
      deadzone_r   <= DEADZONE_RST;
      min_speed_r  <= MIN_SPEED_RST;
      top_speed_r  <= TOP_SPEED_RST;
      period_r     <= PERIOD_RST;
      full_scale_r <= FULL_SCALE_RST;
      gain_r       <= GAIN_RST;
      for (int i = 0; i < 4; i++) begin
        avg_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      // register writes, only while idle by contract
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_DEADZONE:   deadzone_r   <= cfg_data[SMP_W-1:0];
          CFG_MIN_SPEED:  min_speed_r  <= cfg_data[PCT_W-1:0];
          CFG_TOP_SPEED:  top_speed_r  <= cfg_data[PCT_W-1:0];
          CFG_PWM_PERIOD: period_r     <= cfg_data[PER_W-1:0];
          CFG_FULL_SCALE: full_scale_r <= cfg_data[SMP_W-1:0];
          CFG_ROT_GAIN:   gain_r       <= cfg_data[PCT_W-1:0];
          default: ;
        endcase
      end

      // a new result may replace the one taken in the same cycle
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            smp_r[0] <= in_data.sample_up;
            smp_r[1] <= in_data.sample_down;
            smp_r[2] <= in_data.sample_right;
            smp_r[3] <= in_data.sample_left;
            idx_r    <= '0;
          end
        end
        S_SMOOTH: begin
          avg_r[idx_r] <= sm_new;
          idx_r        <= idx_r + 1'b1;
        end
        S_DIFF: begin
          av_r       <= dv[SMP_W] ? SMP_W'(-dv) : dv[SMP_W-1:0];
          ah_r       <= dh[SMP_W] ? SMP_W'(-dh) : dh[SMP_W-1:0];
          dh_neg_r   <= dh[SMP_W];
          tilt_ind_r <= (dv > 0) ? IND_POS : ((dv < 0) ? IND_NEG : IND_IDLE);
          rot_ind_r  <= (dh > 0) ? IND_POS : ((dh < 0) ? IND_NEG : IND_IDLE);
          span_neg_r <= span[PCT_W];
          span_mag_r <= span[PCT_W] ? PCT_W'(-span) : span[PCT_W-1:0];
          phase_r    <= PH_TILT;
        end
        S_MUL: ;
        S_WAIT: begin
          if (div_st.done) begin
            unique case (phase_r)
              PH_TILT: begin
                speed_r <= spd_sat;
                en_r    <= spd_pos;
                up_r    <= spd_pos && (tilt_ind_r == IND_POS);
                down_r  <= spd_pos && (tilt_ind_r != IND_POS);
                phase_r <= PH_TCMP;
              end
              PH_TCMP: begin
                tilt_cmp_r <= div_st.quotient[PER_W-1:0];
                phase_r    <= PH_ROT;
              end
              PH_ROT: begin
                duty_r  <= duty_c;
                phase_r <= PH_RCMP;
              end
              PH_RCMP: begin
                rot_cmp_r <= div_st.quotient[PER_W-1:0];
              end
              default: ;
            endcase
          end
        end
        S_DONE: begin
          // output register frees the datapath once the last item is taken
          if (out_load) begin
            out_r.tilt_up            <= up_r;
            out_r.tilt_down          <= down_r;
            out_r.tilt_enable        <= en_r;
            out_r.tilt_compare       <= tilt_cmp_r;
            out_r.rotation_compare   <= rot_cmp_r;
            out_r.tilt_indicator     <= tilt_ind_r;
            out_r.rotation_indicator <= rot_ind_r;
            out_r.smooth_up          <= int_up;
            out_r.smooth_down        <= int_down;
            out_r.smooth_right       <= int_right;
            out_r.smooth_left        <= int_left;
          end
        end
        default: ;
      endcase
    end
  end

  // an accepted item keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while item in progress");

  // a moving tilt motor has exactly one direction bit
  a_tilt_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.tilt_enable == (out_data.tilt_up ^ out_data.tilt_down))
                  && !(out_data.tilt_up && out_data.tilt_down))
    else $error("tilt direction bits inconsistent with enable");

  // disabled tilt drives no pwm high time
  a_tilt_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.tilt_enable |-> out_data.tilt_compare == '0)
    else $error("tilt compare nonzero while disabled");

  // the divider only finishes while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> state_r == S_WAIT)
    else $error("divider done outside wait state");

endmodule
